@@ rtl/vhts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhts_pkg - shared types and constants for the hash tree sizer
// Widths, digest size table, block size checks and sequencer state codes.
// ----------------------------------------------------------------------------
package vhts_pkg;

	localparam int DIV_W = 64;   // dividend / quotient width
	localparam int DEN_W = 17;   // divisor width: fan-out tops out at 2^16
	localparam int LG_W  = 5;    // log2 of a 32-bit block size
	localparam int CNT_W = $clog2(DIV_W);
	localparam int DS_W  = 7;    // digest bytes, at most 64

	localparam logic [31:0] MIN_BLOCK = 32'd512;
	localparam logic [31:0] MAX_BLOCK = 32'd1 << 20;

	typedef enum logic [3:0] {
		ALG_UNKNOWN    = 4'd0,
		ALG_SHA256     = 4'd1,
		ALG_SHA512_256 = 4'd2,
		ALG_BLAKE2B256 = 4'd3,
		ALG_BLAKE2S256 = 4'd4,
		ALG_SHA1       = 4'd5,
		ALG_SHA224     = 4'd6,
		ALG_SHA384     = 4'd7,
		ALG_SHA512     = 4'd8,
		ALG_BLAKE2B512 = 4'd9,
		ALG_MD5        = 4'd10,
		ALG_RIPEMD160  = 4'd11
	} alg_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_FAN   = 6'b000010,
		S_LEVEL = 6'b000100,
		S_ACC   = 6'b001000,
		S_SIZE  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	// divider result group
	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic             rem_nz;
	} div_res_t;

	function automatic logic [DS_W-1:0] digest_bytes(input logic [3:0] code);
		logic [DS_W-1:0] ds;
		case (code)
			ALG_SHA256, ALG_SHA512_256,
			ALG_BLAKE2B256, ALG_BLAKE2S256: ds = 7'd32;
			ALG_SHA1, ALG_RIPEMD160:        ds = 7'd20;
			ALG_SHA224:                     ds = 7'd28;
			ALG_SHA384:                     ds = 7'd48;
			ALG_SHA512, ALG_BLAKE2B512:     ds = 7'd64;
			ALG_MD5:                        ds = 7'd16;
			default:                        ds = 7'd0;
		endcase
		return ds;
	endfunction

	// power of two within [512, 1 MiB]
	function automatic logic size_ok(input logic [31:0] v);
		return (v != 32'd0) && ((v & (v - 32'd1)) == 32'd0) &&
			(v >= MIN_BLOCK) && (v <= MAX_BLOCK);
	endfunction

	// bit index of a one-hot word
	function automatic logic [LG_W-1:0] log2_onehot(input logic [31:0] v);
		logic [LG_W-1:0] lg;
		lg = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) lg = lg | LG_W'(i);
		end
		return lg;
	endfunction

endpackage

@@ rtl/vhts_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhts_if - item channels of the hash tree sizer
// Valid/ready channels for superblock descriptions and sizing results.
// ----------------------------------------------------------------------------
interface vhts_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_blk_size;
	logic [31:0] hash_blk_size;
	logic [63:0] data_block_count;
	logic [3:0]  algorithm_code;
	logic [63:0] avail_bytes;

	modport source (output valid, data_blk_size, hash_blk_size, data_block_count,
		algorithm_code, avail_bytes, input ready);
	modport sink (input valid, data_blk_size, hash_blk_size, data_block_count,
		algorithm_code, avail_bytes, output ready);
endinterface

interface vhts_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [63:0] region_bytes;
	logic [63:0] region_blocks;

	modport source (output valid, accepted, region_bytes, region_blocks, input ready);
	modport sink (input valid, accepted, region_bytes, region_blocks, output ready);
endinterface

@@ rtl/vhts_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vhts_div - radix-2 restoring divider
// 64-bit dividend by 17-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vhts_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [vhts_pkg::DIV_W-1:0] num,
	input  logic [vhts_pkg::DEN_W-1:0] den,
	output vhts_pkg::div_res_t         res
);

	logic [vhts_pkg::DIV_W-1:0] num_q;   // shifts out dividend, shifts in quotient
	logic [vhts_pkg::DEN_W-1:0] den_q;
	logic [vhts_pkg::DEN_W-1:0] rem_q;
	logic [vhts_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [vhts_pkg::DEN_W:0] trial;
	logic [vhts_pkg::DEN_W:0] diff;
	logic                     ge;

	assign trial = {rem_q, num_q[vhts_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {vhts_pkg::CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[vhts_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? diff[vhts_pkg::DEN_W-1:0] : trial[vhts_pkg::DEN_W-1:0];
		end
	end

	assign res.done   = done_q;
	assign res.quot   = num_q;
	assign res.rem_nz = |rem_q;

endmodule

@@ rtl/verity_hash_tree_sizer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// verity_hash_tree_sizer_top - hash tree region sizer
// Sizes the superblock plus hash tree region of a block-integrity image.
// ----------------------------------------------------------------------------
// Each input item describes one superblock. Both block sizes must be powers
// of two from 512 bytes to 1 MiB, or the result is accepted=0 with zero size
// and block count. The fan-out is hash block size over digest size; the tree
// is then walked level by level with exact ceiling division, all levels
// summed plus one superblock block. region_bytes is that count times the
// hash block size, saturated on overflow and clamped to avail_bytes.
// All divisions go through one shared bit-serial divider: one pass for the
// fan-out, then one per tree level; a single data block needs only the
// fan-out pass, and rejected items, unknown algorithms and empty trees skip
// the divider. The block takes one item at a time; the result sits in an
// output register, so the next item may start while it waits. An item only
// stalls at the end if the previous result is still waiting there.
// ----------------------------------------------------------------------------
module verity_hash_tree_sizer_top (
	input  logic             clk,
	input  logic             arst_n,
	vhts_in_if.sink          in_ch,
	vhts_out_if.source       out_ch
);

	vhts_pkg::state_t state_q;

	// per-item working registers
	logic                        ok_q;        // block sizes passed
	logic [vhts_pkg::LG_W-1:0]   lg_q;        // log2 hash block size
	logic [63:0]                 count_q;
	logic [63:0]                 avail_q;
	logic [vhts_pkg::DS_W-1:0]   ds_q;
	logic [vhts_pkg::DEN_W-1:0]  fan_q;
	logic [63:0]                 level_q;
	logic [63:0]                 total_q;     // wraps like a 64-bit counter
	logic [63:0]                 size_q;

	// output register
	logic        out_valid_q;
	logic        out_acc_q;
	logic [63:0] out_bytes_q;
	logic [63:0] out_blocks_q;

	// shared divider hookup
	logic                       div_start;
	logic [vhts_pkg::DIV_W-1:0] div_num;
	logic [vhts_pkg::DEN_W-1:0] div_den;
	vhts_pkg::div_res_t         div_res;

	logic                       in_fire;
	logic                       in_ok;
	logic [vhts_pkg::DS_W-1:0]  in_ds;
	logic [63:0]                lvl_next;
	logic [127:0]               prod;
	logic                       out_free;

	assign in_ch.ready = (state_q == vhts_pkg::S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign in_ok       = vhts_pkg::size_ok(in_ch.data_blk_size) &&
		vhts_pkg::size_ok(in_ch.hash_blk_size);
	assign in_ds       = vhts_pkg::digest_bytes(in_ch.algorithm_code);

	// ceiling of the quotient
	assign lvl_next = div_res.quot + {63'd0, div_res.rem_nz};

	// total * hash block size as a shift; upper half set means overflow
	assign prod = {64'd0, total_q} << lg_q;

	assign out_free = !out_valid_q || out_ch.ready;

	// divider operand select: fan-out first, then one pass per level
	always_comb begin
		div_start = 1'b0;
		div_num   = level_q;
		div_den   = fan_q;
		unique case (state_q)
			vhts_pkg::S_IDLE: begin
				div_num   = {32'd0, in_ch.hash_blk_size};
				div_den   = vhts_pkg::DEN_W'(in_ds);
				div_start = in_fire && in_ok && (in_ds != '0) &&
					(in_ch.data_block_count != 64'd0);
			end
			vhts_pkg::S_FAN: begin
				div_num   = count_q;
				div_den   = div_res.quot[vhts_pkg::DEN_W-1:0];
				div_start = div_res.done && (div_res.quot >= 64'd2) &&
					(count_q > 64'd1);
			end
			vhts_pkg::S_ACC: begin
				div_start = (level_q > 64'd1);
			end
			vhts_pkg::S_LEVEL, vhts_pkg::S_SIZE, vhts_pkg::S_OUT: begin
				div_start = 1'b0;
			end
			default: div_start = 1'b0;
		endcase
	end

	vhts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vhts_pkg::S_IDLE;
		end else begin
			unique case (state_q)
				vhts_pkg::S_IDLE: begin
					if (div_start) state_q <= vhts_pkg::S_FAN;
					else if (in_fire) state_q <= vhts_pkg::S_SIZE;
				end
				vhts_pkg::S_FAN: begin
					if (div_start) state_q <= vhts_pkg::S_LEVEL;
					else if (div_res.done) state_q <= vhts_pkg::S_SIZE;
				end
				vhts_pkg::S_LEVEL: begin
					if (div_res.done) state_q <= vhts_pkg::S_ACC;
				end
				vhts_pkg::S_ACC: begin
					state_q <= div_start ? vhts_pkg::S_LEVEL : vhts_pkg::S_SIZE;
				end
				vhts_pkg::S_SIZE: state_q <= vhts_pkg::S_OUT;
				vhts_pkg::S_OUT: begin
					if (out_free) state_q <= vhts_pkg::S_IDLE;
				end
				default: state_q <= vhts_pkg::S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ok_q    <= in_ok;
			lg_q    <= vhts_pkg::log2_onehot(in_ch.hash_blk_size);
			count_q <= in_ch.data_block_count;
			avail_q <= in_ch.avail_bytes;
			ds_q    <= in_ds;
			fan_q   <= '0;
			total_q <= 64'd1;
		end
		if (state_q == vhts_pkg::S_FAN && div_res.done) begin
			fan_q   <= div_res.quot[vhts_pkg::DEN_W-1:0];
			level_q <= count_q;
		end
		if (state_q == vhts_pkg::S_LEVEL && div_res.done) begin
			level_q <= lvl_next;
		end
		if (state_q == vhts_pkg::S_ACC) begin
			total_q <= total_q + level_q;
		end
		if (state_q == vhts_pkg::S_SIZE) begin
			if (!ok_q) size_q <= 64'd0;
			else if (|prod[127:64]) size_q <= {64{1'b1}};
			else size_q <= prod[63:0];
		end
	end

	// output register: clamp to avail on load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == vhts_pkg::S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == vhts_pkg::S_OUT && out_free) begin
			out_acc_q    <= ok_q;
			out_bytes_q  <= (size_q > avail_q) ? avail_q : size_q;
			out_blocks_q <= ok_q ? total_q : 64'd0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.accepted      = out_acc_q;
	assign out_ch.region_bytes  = out_bytes_q;
	assign out_ch.region_blocks = out_blocks_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_acc_q) |-> (out_bytes_q == 64'd0 && out_blocks_q == 64'd0))
		else $error("rejected item carries a nonzero size");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == vhts_pkg::S_FAN || state_q == vhts_pkg::S_LEVEL))
		else $error("divider finished outside a division state");

	a_fan_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vhts_pkg::S_LEVEL) |-> (fan_q >= vhts_pkg::DEN_W'(2) && ds_q != '0))
		else $error("level walk with fan-out below two");

	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vhts_pkg::S_OUT && out_valid_q && !out_ch.ready) |=>
		(state_q == vhts_pkg::S_OUT))
		else $error("result left before the output register freed");

endmodule
